[src/utf16_to_utf8_encoder_top_macros.svh]
// Assertion macros shared by the transcoder RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef UTF16_TO_UTF8_ENCODER_TOP_MACROS_SVH
`define UTF16_TO_UTF8_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset
`define UTE_ASSERT(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("utf16_to_utf8_encoder: check failed");

// Consequent must hold in the same cycle as the antecedent
`define UTE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf16_to_utf8_encoder: check failed");

// Consequent must hold in the cycle after the antecedent
`define UTE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf16_to_utf8_encoder: check failed");

`else

`define UTE_ASSERT(name, cond)
`define UTE_ASSERT_IMP(name, ante, cons)
`define UTE_ASSERT_NEXT(name, ante, cons)

`endif

`endif

[src/utf_enc_pkg.sv]
package utf_enc_pkg;

  // Surrogate classification
  localparam logic [15:0] SUR_MASK = 16'hFC00;
  localparam logic [15:0] HIGH_SUR = 16'hD800;
  localparam logic [15:0] LOW_SUR  = 16'hDC00;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // UTF-8 length thresholds
  localparam logic [20:0] LIM_1B = 21'h00080;
  localparam logic [20:0] LIM_2B = 21'h00800;
  localparam logic [20:0] LIM_3B = 21'h10000;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  // Sequence length minus one
  localparam logic [1:0] LEN1 = 2'd0;
  localparam logic [1:0] LEN2 = 2'd1;
  localparam logic [1:0] LEN3 = 2'd2;
  localparam logic [1:0] LEN4 = 2'd3;

  // One queued job: one or two values to encode back to back
  typedef struct packed {
    logic [20:0] v0;
    logic [20:0] v1;
    logic        two;
  } job_t;

  // Number of UTF-8 bytes minus one for a value
  function automatic logic [1:0] enc_len(input logic [20:0] v);
    logic [1:0] r;
    if (v < LIM_1B) begin
      r = LEN1;
    end else if (v < LIM_2B) begin
      r = LEN2;
    end else if (v < LIM_3B) begin
      r = LEN3;
    end else begin
      r = LEN4;
    end
    return r;
  endfunction

  // Byte idx of the UTF-8 sequence of v
  function automatic logic [7:0] enc_byte(input logic [20:0] v, input logic [1:0] len_m1,
                                          input logic [1:0] idx);
    logic [1:0] sh;
    logic [5:0] chunk;
    logic [7:0] r;
    sh = len_m1 - idx;
    unique case (sh)
      2'd0: chunk = v[5:0];
      2'd1: chunk = v[11:6];
      2'd2: chunk = v[17:12];
      default: chunk = {3'b000, v[20:18]};
    endcase
    if (idx == 2'd0) begin
      unique case (len_m1)
        LEN1: r = v[7:0];
        LEN2: r = LEAD2 | {3'b000, v[10:6]};
        LEN3: r = LEAD3 | {4'b0000, v[15:12]};
        default: r = LEAD4 | {5'b00000, v[20:18]};
      endcase
    end else begin
      r = CONT | {2'b00, chunk};
    end
    return r;
  endfunction

endpackage

[src/utf16_to_utf8_encoder_top.sv]
// UTF-16 to UTF-8 transcoder.
// Input queue port: code_value is taken on a rising edge with push high and
// full low. Each item is a UTF-16 code unit or a whole code point; 0 flushes
// a held high surrogate. A high surrogate is held until the next item: a low
// surrogate then forms a 4-byte sequence, anything else sends the held unit
// as 3 bytes before encoding the new item.
// Output queue port: while empty is low, out_byte/last_byte show the oldest
// byte; it is taken on a rising edge with pop high. last_byte marks the final
// byte caused by one input item. Items that cause no bytes produce nothing.
// The first byte of an item is registered in the job queue, then in out_byte.
// Throughput: the byte emitter sends one byte per cycle unless the receiver
// stalls, so an item gives 1 to 7 bytes at the output (1 to 4 for most text).
// While bytes drain, the QUEUE_DEPTH-entry job queue takes one item per cycle.
// Reset (rst, synchronous) drops any held surrogate and all queued bytes.
// When the receiver stalls, the output byte holds, the job queue fills and
// full rises.
module utf16_to_utf8_encoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [20:0] code_value,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_byte
);
  import utf_enc_pkg::*;

  job_t q_wdata;
  job_t q_rdata;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  // Accept and classify
  utf_enc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .code_value (code_value),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  // Jobs between classifier and emitter
  utf_enc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // Byte emitter
  utf_enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (q_rdata),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .out_byte  (out_byte),
    .last_byte (last_byte),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

[src/utf_enc_front.sv]
module utf_enc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [20:0]        code_value,
  input  logic               q_full,
  output logic               q_push,
  output utf_enc_pkg::job_t  q_data
);
  import utf_enc_pkg::*;

  logic [15:0] pending;
  logic        accept;
  logic        is_high;
  logic        is_low;
  logic        held;
  logic [20:0] pair_cp;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign held   = (pending != 16'h0000);

  // Surrogates only exist below the supplementary planes
  assign is_high = (code_value[20:16] == 5'd0) && ((code_value[15:0] & SUR_MASK) == HIGH_SUR);
  assign is_low  = (code_value[20:16] == 5'd0) && ((code_value[15:0] & SUR_MASK) == LOW_SUR);
  assign pair_cp = {1'b0, pending[9:0], code_value[9:0]} + SUPP_BASE;

  // Classify the item into a job for the byte emitter
  always_comb begin
    q_push = 1'b0;
    q_data = '{v0: code_value, v1: code_value, two: 1'b0};
    if (!held) begin
      q_push = accept && !is_high && (code_value != 21'd0);
    end else if (is_low) begin
      q_push    = accept;
      q_data.v0 = pair_cp;
    end else begin
      q_push     = accept;
      q_data.v0  = {5'd0, pending};
      q_data.two = (code_value != 21'd0);
    end
  end

  // Held high surrogate
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 16'h0000;
    end else if (accept) begin
      if (!held && is_high) begin
        pending <= code_value[15:0];
      end else begin
        pending <= 16'h0000;
      end
    end
  end

  `include "utf16_to_utf8_encoder_top_macros.svh"

  `UTE_ASSERT(a_pending_is_high, !held || ((pending & SUR_MASK) == HIGH_SUR))
  `UTE_ASSERT_NEXT(a_held_clears, accept && held, !held)

endmodule

[src/utf_enc_fifo.sv]
module utf_enc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  utf_enc_pkg::job_t  wr_data,
  output logic               full,
  input  logic               rd_en,
  output utf_enc_pkg::job_t  rd_data,
  output logic               empty
);
  import utf_enc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `include "utf16_to_utf8_encoder_top_macros.svh"

  `UTE_ASSERT(a_count_bound, count <= FULL_CNT)

endmodule

[src/utf_enc_back.sv]
module utf_enc_back (
  input  logic               clk,
  input  logic               rst,
  input  utf_enc_pkg::job_t  job,
  input  logic               job_empty,
  output logic               job_pop,
  output logic [7:0]         out_byte,
  output logic               last_byte,
  output logic               empty,
  input  logic               pop
);
  import utf_enc_pkg::*;

  logic        sel;
  logic [1:0]  idx;
  logic        out_valid;
  logic [20:0] cur;
  logic [1:0]  len_m1;
  logic        slot_free;
  logic        fire;
  logic        val_done;
  logic        job_done;

  assign cur       = sel ? job.v1 : job.v0;
  assign len_m1    = enc_len(cur);
  assign slot_free = !out_valid || pop;
  assign fire      = !job_empty && slot_free;
  assign val_done  = (idx == len_m1);
  assign job_done  = val_done && (sel || !job.two);
  assign job_pop   = fire && job_done;
  assign empty     = !out_valid;

  // Walk through the bytes of the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
      idx <= 2'd0;
    end else if (fire) begin
      if (val_done) begin
        sel <= !job_done;
        idx <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte  <= enc_byte(cur, len_m1, idx);
      last_byte <= job_done;
    end
  end

  `include "utf16_to_utf8_encoder_top_macros.svh"

  `UTE_ASSERT_IMP(a_second_needs_two, sel, !job_empty && job.two)
  `UTE_ASSERT_IMP(a_idx_in_range, !job_empty, idx <= len_m1)

endmodule
